// ===== rtl/mwwa_pkg.sv =====
package mwwa_pkg;

  localparam int SampleBits = 16;
  localparam int WeightBits = 16;
  localparam int MaxSlots   = 15;
  localparam int SlotW      = 4;
  localparam int HalfW      = 3;
  // 15 products of 16 x 17 signed bits
  localparam int NumBits    = SampleBits + WeightBits + 1 + 4;
  // 15 weights of at most 16 bits
  localparam int DenBits    = WeightBits + 4;
  localparam logic [WeightBits-1:0] Unity = 16'h8000;

  localparam logic [2:0] RegHalfWidth = 3'd0;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         first_of_series;
    logic                         last_of_series;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] smoothed;
    logic                         last_out;
  } out_t;

  // One output to compute: a snapshot of the window and its center.
  typedef struct packed {
    logic [MaxSlots-1:0][SampleBits-1:0] win;
    logic [MaxSlots-1:0]                 vld;
    logic [SlotW-1:0]                    centre;
    logic [HalfW-1:0]                    half;
    logic                                last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/mwwa_queue.sv =====
module mwwa_queue import mwwa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      push_data_i,
  input  logic      pop_i,
  output job_t      pop_data_o,
  output q_status_t status_o
);

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/mwwa_front.sv =====
module mwwa_front import mwwa_pkg::*; #(
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  input  logic [HalfW-1:0] half_width_i,
  input  q_status_t        q_status_i,
  output logic             push_o,
  output job_t             push_data_o,
  output logic             flushing_o
);

  localparam int Win  = 2 * MAX_HALF_WIDTH + 1;
  localparam int IdxW = $clog2(Win);

  typedef enum logic {F_RUN, F_FLUSH} state_e;

  state_e                 state_q;
  logic [SampleBits-1:0]  win_q [Win];
  logic [Win-1:0]         vld_q;
  logic [IdxW-1:0]        c_q;
  logic [HalfW-1:0]       hf_q;

  logic [SampleBits-1:0]  win_new [Win];
  logic [Win-1:0]         vld_new;
  logic [HalfW-1:0]       h;
  logic                   accept;

  assign h = (half_width_i > HalfW'(MAX_HALF_WIDTH)) ? HalfW'(MAX_HALF_WIDTH)
                                                      : half_width_i;
  assign in_stall_o = (state_q == F_FLUSH) || q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign flushing_o = (state_q == F_FLUSH);

  // shift the new sample in; a first mark clears the old series
  always_comb begin
    win_new[0] = in_data_i.sample;
    vld_new[0] = 1'b1;
    for (int k = 1; k < Win; k++) begin
      win_new[k] = in_data_i.first_of_series ? '0 : win_q[k-1];
      vld_new[k] = in_data_i.first_of_series ? 1'b0 : vld_q[k-1];
    end
  end

  always_comb begin
    push_data_o = '0;
    push_o      = 1'b0;
    if (state_q == F_RUN) begin
      for (int k = 0; k < Win; k++) begin
        push_data_o.win[k] = win_new[k];
        push_data_o.vld[k] = vld_new[k];
      end
      push_data_o.centre = SlotW'(h);
      push_data_o.half   = h;
      push_data_o.last   = 1'b0;
      push_o = accept && !in_data_i.last_of_series && vld_new[IdxW'(h)];
    end else begin
      for (int k = 0; k < Win; k++) begin
        push_data_o.win[k] = win_q[k];
        push_data_o.vld[k] = vld_q[k];
      end
      push_data_o.centre = SlotW'(c_q);
      push_data_o.half   = hf_q;
      push_data_o.last   = (c_q == '0);
      push_o = vld_q[c_q] && !q_status_i.full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_RUN;
      vld_q   <= '0;
      c_q     <= '0;
      hf_q    <= '0;
      for (int k = 0; k < Win; k++) win_q[k] <= '0;
    end else begin
      unique case (state_q)
        F_RUN: begin
          if (accept) begin
            for (int k = 0; k < Win; k++) win_q[k] <= win_new[k];
            vld_q <= vld_new;
            if (in_data_i.last_of_series) begin
              c_q     <= IdxW'(h);
              hf_q    <= h;
              state_q <= F_FLUSH;
            end
          end
        end
        F_FLUSH: begin
          if (!q_status_i.full) begin
            if (c_q == '0) begin
              vld_q   <= '0;
              for (int k = 0; k < Win; k++) win_q[k] <= '0;
              state_q <= F_RUN;
            end else begin
              c_q <= c_q - IdxW'(1);
            end
          end
        end
        default: state_q <= F_RUN;
      endcase
    end
  end

endmodule

// ===== rtl/mwwa_back.sv =====
module mwwa_back import mwwa_pkg::*; #(
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q_status_t             q_status_i,
  input  job_t                  job_i,
  output logic                  pop_o,
  input  logic [WeightBits-1:0] tap_i [1:7],
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int Win  = 2 * MAX_HALF_WIDTH + 1;
  localparam int IdxW = $clog2(Win);
  localparam int CntW = $clog2(NumBits);
  localparam int ProdBits = SampleBits + WeightBits + 1;

  typedef enum logic [2:0] {B_IDLE, B_ACC, B_PREP, B_DIV, B_DONE} state_e;

  state_e                      state_q;
  job_t                        job_q;
  logic [IdxW-1:0]             k_q;
  logic signed [NumBits-1:0]   num_q;
  logic [DenBits-1:0]          den_q;
  logic [DenBits-1:0]          rem_q;
  logic [NumBits-1:0]          quot_q;
  logic [CntW-1:0]             cnt_q;
  logic                        neg_q;
  logic                        out_valid_q;
  out_t                        out_data_q;

  logic [SlotW-1:0]            tap_dist;
  logic signed [SampleBits-1:0] s;
  logic [WeightBits-1:0]       w;
  logic                        use_slot;
  logic signed [ProdBits-1:0]  prod;
  logic [DenBits:0]            rem_sh;
  logic                        fits;
  logic [NumBits-1:0]          q_signed;

  assign pop_o = (state_q == B_IDLE) && !q_status_i.empty;

  always_comb begin
    s    = job_q.win[SlotW'(k_q)];
    tap_dist = (SlotW'(k_q) > job_q.centre) ? SlotW'(k_q) - job_q.centre
                                            : job_q.centre - SlotW'(k_q);
    w    = (tap_dist == '0) ? Unity
                            : tap_i[tap_dist[2:0] == 3'd0 ? 3'd1 : tap_dist[2:0]];
    use_slot = job_q.vld[SlotW'(k_q)] && (tap_dist <= SlotW'(job_q.half)) &&
               (s != '0) && (tap_dist <= SlotW'(7));
    prod = s * $signed({1'b0, w});
  end

  assign rem_sh   = {rem_q, quot_q[NumBits-1]};
  assign fits     = (rem_sh >= {1'b0, den_q});
  assign q_signed = neg_q ? (~quot_q + NumBits'(1)) : quot_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      num_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      quot_q      <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (state_q == B_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q         <= 1'b1;
        out_data_q.smoothed <= q_signed[SampleBits-1:0];
        out_data_q.last_out <= job_q.last;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            k_q     <= '0;
            num_q   <= '0;
            den_q   <= '0;
            state_q <= B_ACC;
          end
        end
        B_ACC: begin
          if (use_slot) begin
            num_q <= num_q + NumBits'(prod);
            den_q <= den_q + DenBits'(w);
          end
          if (k_q == IdxW'(Win - 1)) begin
            state_q <= B_PREP;
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end
        B_PREP: begin
          rem_q <= '0;
          cnt_q <= CntW'(NumBits - 1);
          if (den_q == '0) begin
            quot_q  <= '0;
            neg_q   <= 1'b0;
            state_q <= B_DONE;
          end else begin
            neg_q   <= num_q[NumBits-1];
            quot_q  <= num_q[NumBits-1] ? (~num_q + NumBits'(1)) : num_q;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          rem_q  <= fits ? DenBits'(rem_sh - {1'b0, den_q}) : rem_sh[DenBits-1:0];
          quot_q <= {quot_q[NumBits-2:0], fits};
          if (cnt_q == '0) begin
            state_q <= B_DONE;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        B_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/masked_window_weighted_average.sv =====
// Channel | Dir | Handshake                   | Payload
// --------+-----+-----------------------------+--------------------------------
// in      | in  | in_valid_i / in_stall_o     | in_data_i  (sample, first, last)
// out     | out | out_valid_o / out_stall_i   | out_data_o (smoothed, last_out)
// cfg     | in  | APB psel/penable/pwrite     | half_width, tap_weight_1..7
//
// In the back end each result goes one slot per cycle through the
// multiply-accumulate, then through a one-bit-per-cycle restoring divider.
// The front takes one sample per cycle while the two-entry job queue has room
// and it is not flushing; sustained, that is about one sample per result.
// A last mark then holds stall while it flushes, stepping the centre from
// half_width down to 0, and the flush waits while the queue is full.
// Reset clears the window, the queue and the output register; no sweep.
// The output register lets the back end start the next job under out stall.
module masked_window_weighted_average import mwwa_pkg::*; #(
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [HalfW-1:0]      half_width_q;
  logic [WeightBits-1:0] tap_q [1:7];
  logic [2:0]            reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HalfW'(1);
      for (int d = 1; d < 8; d++) tap_q[d] <= Unity;
    end else if (cfg_wr) begin
      if (reg_idx == RegHalfWidth) begin
        half_width_q <= pwdata[HalfW-1:0];
      end else begin
        tap_q[reg_idx] <= pwdata[WeightBits-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == RegHalfWidth) begin
      prdata = {{(32-HalfW){1'b0}}, half_width_q};
    end else begin
      prdata = {{(32-WeightBits){1'b0}}, tap_q[reg_idx]};
    end
  end

  // front end: window and job issue
  logic      q_push, q_pop, flushing;
  job_t      q_wdata, q_rdata;
  q_status_t q_status;

  mwwa_front #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .half_width_i (half_width_q),
    .q_status_i   (q_status),
    .push_o       (q_push),
    .push_data_o  (q_wdata),
    .flushing_o   (flushing)
  );

  mwwa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  // back end: weighted sum and division
  mwwa_back #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (q_rdata),
    .pop_o       (q_pop),
    .tap_i       (tap_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty) else $error("job queue underflow");
  a_flush_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing |-> in_stall_o) else $error("input taken during flush");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mwwa_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainWait  = 200;  // > one back-end result plus flush stall

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  masked_window_weighted_average dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: configuration and the sample window, index 0 newest.
  logic [2:0]              half_sh;
  logic [WeightBits-1:0]   tap_sh [1:7];
  logic signed [SampleBits-1:0] win_sh [MaxSlots];
  bit                      vld_sh [MaxSlots];

  in_t  samples_pending [$];
  out_t averages_due [$];
  int   errors;
  int   accepted;
  int   produced;
  int   cycles;
  bit   hold_off;

  task automatic clear_shadow();
    for (int k = 0; k < MaxSlots; k++) begin
      win_sh[k] = '0;
      vld_sh[k] = 1'b0;
    end
  endtask

  // Weighted mean of nonzero samples within h of centre c, truncated to zero.
  function automatic logic signed [SampleBits-1:0] weighted_mean(int c, int h);
    longint num;
    longint den;
    longint w;
    int d;
    num = 0;
    den = 0;
    for (int k = 0; k < MaxSlots; k++) begin
      if (vld_sh[k] && win_sh[k] != 0) begin
        d = (k > c) ? k - c : c - k;
        if (d <= h) begin
          w = (d == 0) ? longint'(Unity) : longint'(tap_sh[d]);
          num += longint'(win_sh[k]) * w;
          den += w;
        end
      end
    end
    if (den == 0) return '0;
    return SampleBits'(num / den);
  endfunction

  task automatic predict_averages(in_t it);
    int h;
    out_t r;
    h = half_sh;
    // a first mark mid-series drops the old window
    if (it.first_of_series) clear_shadow();
    for (int k = MaxSlots - 1; k > 0; k--) begin
      win_sh[k] = win_sh[k-1];
      vld_sh[k] = vld_sh[k-1];
    end
    win_sh[0] = it.sample;
    vld_sh[0] = 1'b1;
    if (!it.last_of_series) begin
      if (vld_sh[h]) begin
        r.smoothed = weighted_mean(h, h);
        r.last_out = 1'b0;
        averages_due.push_back(r);
      end
    end else begin
      // flush: only centres that hold a sample, newest carries last_out
      for (int c = h; c >= 0; c--) begin
        if (vld_sh[c]) begin
          r.smoothed = weighted_mean(c, h);
          r.last_out = (c == 0);
          averages_due.push_back(r);
        end
      end
      clear_shadow();
    end
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, produced);
  endtask

  // Driver: one transaction at a time, random gaps between them.
  int send_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_averages(in_data);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          in_data  <= samples_pending.pop_front();
          in_valid <= 1'b1;
          send_gap <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  int recv_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
      recv_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (averages_due.size() == 0) begin
          report_mismatch("unexpected result", out_data.smoothed, 0);
        end else begin
          out_t want;
          want = averages_due.pop_front();
          if (out_data.smoothed !== want.smoothed)
            report_mismatch("smoothed", out_data.smoothed, want.smoothed);
          if (out_data.last_out !== want.last_out)
            report_mismatch("last_out", out_data.last_out, want.last_out);
        end
        produced++;
      end
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
        recv_gap  <= idle_len();
      end
    end
  end

  // Long receiver hold-off so the job queue fills and the input stalls.
  initial begin
    hold_off = 1'b0;
    wait (accepted >= 120);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(int idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == 0) half_sh = val[2:0];
    else tap_sh[idx] = val[WeightBits-1:0];
  endtask

  task automatic push_sample(logic signed [SampleBits-1:0] s, bit f, bit l);
    in_t it;
    it.sample = s;
    it.first_of_series = f;
    it.last_of_series = l;
    samples_pending.push_back(it);
  endtask

  function automatic logic signed [SampleBits-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r == 3) return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
    return SampleBits'($urandom);
  endfunction

  // Mostly framed series of random length; some noise and broken framing.
  task automatic queue_series(int count);
    int len;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (r == 0) push_sample(rand_sample(), $urandom_range(0, 5) == 0,
                                $urandom_range(0, 5) == 0);
        else if (r == 1) push_sample(rand_sample(), 1'b0, i == len - 1);
        else push_sample(rand_sample(), i == 0, i == len - 1);
      end
    end
  endtask

  task automatic drain();
    while (samples_pending.size() != 0 || in_valid || averages_due.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic random_taps(bit wide);
    for (int d = 1; d <= 7; d++)
      reg_write(d, wide ? $urandom_range(0, 65535) : $urandom_range(0, 32768));
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    accepted = 0;
    produced = 0;
    cycles = 0;
    half_sh = 3'd1;
    for (int d = 1; d <= 7; d++) tap_sh[d] = Unity;
    clear_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset config: extremes, all-excluded, short series, odd framing.
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh8000, 1'b0, 1'b0);
    push_sample(16'sh7fff, 1'b0, 1'b1);
    push_sample(16'sh0000, 1'b1, 1'b0);
    push_sample(16'sh0000, 1'b0, 1'b0);
    push_sample(16'sh0000, 1'b0, 1'b1);
    push_sample(-16'sd5, 1'b1, 1'b1);
    push_sample(16'sd100, 1'b0, 1'b0);   // no first mark after a flush
    push_sample(16'sd7, 1'b0, 1'b0);
    push_sample(16'sd9, 1'b1, 1'b0);     // first mark mid-series
    push_sample(-16'sd3, 1'b0, 1'b1);
    drain();

    reg_write(0, 32'd7);
    for (int d = 1; d <= 7; d++) reg_write(d, 32'h0000ffff);  // weights above one
    for (int i = 0; i < 9; i++) push_sample(i[0] ? 16'sh8000 : 16'sh7fff, i == 0, i == 8);
    push_sample(16'sd1, 1'b1, 1'b0);
    push_sample(16'sd2, 1'b0, 1'b1);      // series shorter than the window
    drain();

    reg_write(0, 32'd0);
    queue_series(8);
    drain();

    reg_write(0, 32'd7);
    for (int d = 1; d <= 7; d++) reg_write(d, 32'd0);  // neighbours weightless
    queue_series(7);
    drain();

    reg_write(0, 32'd3);
    random_taps(1'b0);
    queue_series(18);
    push_sample(rand_sample(), 1'b1, 1'b0);
    for (int i = 0; i < 6; i++) push_sample(rand_sample(), 1'b0, 1'b0);
    drain();

    reg_write(0, 32'd5);                  // half width changed mid-series
    random_taps(1'b1);
    queue_series(14);
    drain();

    reg_write(0, 32'd7);
    for (int d = 1; d <= 7; d++) reg_write(d, 32'd32768);  // box
    queue_series(12);
    drain();

    reg_write(0, $urandom_range(1, 6));
    random_taps(1'b0);
    queue_series(14);
    drain();

    $display("covered %0d samples, %0d averages, half widths 0..7, box/zero/wide taps",
             accepted, produced);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
